>>> src/fbfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Free block fit search package
// Shared types, field widths, codes and default sizes for the fit search block.
// ----------------------------------------------------------------------------
package fbfs_pkg;

  localparam int DEF_ENTRIES   = 64;
  localparam int DEF_LISTS     = 2;
  localparam int DEF_SIZE_BITS = 32;

  localparam int LIST_SEL_W = 1;
  localparam int INDEX_W    = 6;
  localparam int FIELD_W    = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic REG_FIT_POLICY = 1'b0;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } fit_policy_t;

  typedef struct packed {
    logic                  kind;
    logic [LIST_SEL_W-1:0] list_select;
    logic [INDEX_W-1:0]    entry_index;
    logic [FIELD_W-1:0]    entry_size;
    logic                  entry_valid;
    logic [FIELD_W-1:0]    request_size;
  } fbfs_in_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] block_index;
    logic [FIELD_W-1:0] block_size;
  } fbfs_out_t;

endpackage
`default_nettype wire

>>> src/fbfs_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fit search channel
// Valid/ready channel that carries one payload word per handshake.
// ----------------------------------------------------------------------------
interface fbfs_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/free_block_fit_search.sv
`default_nettype none
// A write word is accepted back to back.
// A search word reads one table entry per cycle from the single read port of the table
// memory; first and next fit end at the hit. The next word is accepted once the
// result is in the output register.
// After reset a clearing pass over all LISTS*ENTRIES entries empties the tables; no word
// is accepted during it, while register writes are taken at all times.
// ----------------------------------------------------------------------------
// Free block fit search
// Free-list tables held in one synchronous memory, scanned entry by entry under
// first, next, best or worst fit, with one resume position per list.
// ----------------------------------------------------------------------------
module free_block_fit_search #(
  parameter int ENTRIES   = fbfs_pkg::DEF_ENTRIES,
  parameter int LISTS     = fbfs_pkg::DEF_LISTS,
  parameter int SIZE_BITS = fbfs_pkg::DEF_SIZE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  fbfs_chan_if.sink                             in_ch,
  fbfs_chan_if.source                           out_ch,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fbfs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [fbfs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [fbfs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import fbfs_pkg::*;

  localparam int DEPTH  = LISTS * ENTRIES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int LIST_W = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int SZX_W  = (SIZE_BITS > FIELD_W) ? SIZE_BITS : FIELD_W;
  localparam int IDXX_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  state_t                  state_r;
  fit_policy_t             fit_policy_r;
  logic [ADDR_W-1:0]       clr_cnt_r;
  logic [LIST_W-1:0]       list_r;
  logic [SIZE_BITS-1:0]    need_r;
  logic [IDX_W-1:0]        iss_pos_r;
  logic [CNT_W-1:0]        issue_cnt_r;
  logic [CNT_W-1:0]        chk_cnt_r;
  logic                    chk_vld_r;
  logic [IDX_W-1:0]        chk_pos_r;
  logic                    hit_r;
  logic [IDX_W-1:0]        pick_r;
  logic [SIZE_BITS-1:0]    pick_size_r;
  logic [IDX_W-1:0]        resume_r [LISTS];
  logic                    out_valid_r;
  fbfs_out_t               out_data_r;

  logic [SIZE_BITS:0]      mem [DEPTH];
  logic [SIZE_BITS:0]      rd_data_r;

  logic                    in_accept;
  logic                    cfg_wr;
  logic                    list_ok;
  logic                    index_ok;
  logic [LIST_W-1:0]       list_in;
  logic [SZX_W-1:0]        esize_ext;
  logic [SZX_W-1:0]        need_ext;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [SIZE_BITS:0]      mem_wdata;
  logic [ADDR_W-1:0]       mem_raddr;
  logic                    issue_en;
  logic                    eval_en;
  logic [SIZE_BITS-1:0]    cand_size;
  logic                    cand_fit;
  logic                    better;
  logic                    take;
  logic                    scan_done;
  logic                    hit_nxt;
  logic [IDX_W-1:0]        pick_nxt;
  logic                    out_load;
  logic [SZX_W-1:0]        pick_size_ext;
  logic [IDXX_W-1:0]       pick_ext;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] pos);
    logic [IDX_W-1:0] res;
    if (pos == IDX_W'(ENTRIES - 1)) begin
      res = '0;
    end else begin
      res = pos + 1'b1;
    end
    return res;
  endfunction

  assign in_accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign list_ok = (32'(in_ch.data.list_select) < 32'(LISTS));
  assign index_ok = (32'(in_ch.data.entry_index) < 32'(ENTRIES));
  assign list_in = list_ok ? LIST_W'(in_ch.data.list_select) : '0;
  assign esize_ext = SZX_W'(in_ch.data.entry_size);
  assign need_ext = SZX_W'(in_ch.data.request_size);

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FIT_POLICY) ? CFG_DATA_W'(fit_policy_r) : '0;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = in_accept && (in_ch.data.kind == KIND_WRITE) && list_ok && index_ok;
      mem_waddr = ADDR_W'(list_in) * ADDR_W'(ENTRIES)
                + ADDR_W'(IDX_W'(in_ch.data.entry_index));
      mem_wdata = {in_ch.data.entry_valid, esize_ext[SIZE_BITS-1:0]};
    end
  end

  assign mem_raddr = ADDR_W'(list_r) * ADDR_W'(ENTRIES) + ADDR_W'(iss_pos_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign issue_en  = (state_r == ST_SCAN) && (issue_cnt_r < CNT_W'(ENTRIES));
  assign eval_en   = (state_r == ST_SCAN) && chk_vld_r;
  assign cand_size = rd_data_r[SIZE_BITS-1:0];
  assign cand_fit  = rd_data_r[SIZE_BITS] && (need_r <= cand_size);
  assign better    = !hit_r
                   || ((fit_policy_r == POL_BEST) && (cand_size < pick_size_r))
                   || ((fit_policy_r == POL_WORST) && (cand_size > pick_size_r));
  assign take      = eval_en && cand_fit && better;
  assign scan_done = eval_en
                   && ((((fit_policy_r == POL_FIRST) || (fit_policy_r == POL_NEXT)) && cand_fit)
                   || (chk_cnt_r == CNT_W'(ENTRIES - 1)));
  assign hit_nxt   = hit_r || take;
  assign pick_nxt  = take ? chk_pos_r : pick_r;
  assign out_load  = (state_r == ST_RESULT) && (!out_valid_r || out_ch.ready);

  assign pick_size_ext = SZX_W'(pick_size_r);
  assign pick_ext      = IDXX_W'(pick_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      fit_policy_r <= POL_FIRST;
      clr_cnt_r    <= '0;
      chk_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int l = 0; l < LISTS; l++) begin
        resume_r[l] <= '0;
      end
    end else begin
      if (cfg_wr && (paddr[2] == REG_FIT_POLICY)) begin
        fit_policy_r <= fit_policy_t'(pwdata[1:0]);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept && (in_ch.data.kind == KIND_SEARCH)) begin
            list_r      <= list_in;
            need_r      <= need_ext[SIZE_BITS-1:0];
            hit_r       <= 1'b0;
            pick_r      <= '0;
            pick_size_r <= '0;
            chk_vld_r   <= 1'b0;
            issue_cnt_r <= '0;
            chk_cnt_r   <= '0;
            iss_pos_r   <= (fit_policy_r == POL_NEXT) ? resume_r[list_in] : '0;
            state_r     <= list_ok ? ST_SCAN : ST_RESULT;
          end
        end
        ST_SCAN: begin
          if (issue_en) begin
            iss_pos_r   <= wrap_inc(iss_pos_r);
            issue_cnt_r <= issue_cnt_r + 1'b1;
          end
          chk_vld_r <= issue_en;
          chk_pos_r <= iss_pos_r;
          if (eval_en) begin
            chk_cnt_r <= chk_cnt_r + 1'b1;
          end
          if (take) begin
            hit_r       <= 1'b1;
            pick_r      <= chk_pos_r;
            pick_size_r <= cand_size;
          end
          if (scan_done) begin
            state_r <= ST_RESULT;
            if ((fit_policy_r == POL_NEXT) && hit_nxt) begin
              resume_r[list_r] <= wrap_inc(pick_nxt);
            end
          end
        end
        ST_RESULT: begin
          if (out_load) begin
            out_data_r.found       <= hit_r;
            out_data_r.block_index <= hit_r ? pick_ext[INDEX_W-1:0] : '0;
            out_data_r.block_size  <= hit_r ? pick_size_ext[FIELD_W-1:0] : '0;
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

`ifndef ASSERT_OFF
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !mem_we)
    else $error("Table written while a search scans it.");

  a_hit_fits: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RESULT) && hit_r) |-> (need_r <= pick_size_r))
    else $error("Chosen block is smaller than the request.");

  a_resume_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (32'(resume_r[list_r]) < 32'(ENTRIES)))
    else $error("Resume position beyond the table.");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found)
      |-> ((out_data_r.block_index == '0) && (out_data_r.block_size == '0)))
    else $error("Miss result carries a nonzero index or size.");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (issue_cnt_r <= CNT_W'(ENTRIES)))
    else $error("Scan issued more reads than table entries.");
`endif

endmodule
`default_nettype wire

>>> sim/free_block_fit_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Free block fit search testbench
// Drives table writes and fit searches through valid/ready channels under all four fit
// policies and checks every result word against a local table model or a scripted word.
// ----------------------------------------------------------------------------
module free_block_fit_search_test;
  import fbfs_pkg::*;

  localparam int ENTRY_COUNT   = DEF_ENTRIES;
  localparam int LIST_COUNT    = DEF_LISTS;
  localparam int SETTLE_CYCLES = ENTRY_COUNT + 16;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SCRIPT_ROWS   = 25;
  localparam int BLOCKS        = 12;
  localparam int BLOCK_WORDS   = 156;

  localparam logic [CFG_ADDR_W-1:0] ADDR_FIT_POLICY = {REG_FIT_POLICY, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_NO_REG     = 3'd4;
  localparam fbfs_out_t             NOT_FOUND       = '0;

  typedef struct {
    fit_policy_t pol;
    fbfs_in_t    word;
    bit          typed;
    fbfs_out_t   result;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  fbfs_chan_if #(.T(fbfs_in_t))  in_ch ();
  fbfs_chan_if #(.T(fbfs_out_t)) out_ch ();

  free_block_fit_search dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready)
  );

  bit [FIELD_W-1:0] sizes_q [LIST_COUNT][ENTRY_COUNT];
  bit               valid_q [LIST_COUNT][ENTRY_COUNT];
  int               resume_q [LIST_COUNT];
  fit_policy_t      policy_q = POL_FIRST;
  fbfs_out_t        expected_results [$];
  int               fail_count = 0;
  int               cycle_count = 0;
  int               src_idle_pct = 19;
  int               snk_idle_pct = 77;
  bit               hold_req = 1'b0;
  bit               hold_done = 1'b0;
  script_row_t      script [SCRIPT_ROWS];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Applies one accepted word to the local tables; returns 1 when a result word follows.
  function automatic bit track_word(input fbfs_in_t w, output fbfs_out_t r);
    int  l;
    int  p;
    int  pick;
    bit  hit;
    l    = w.list_select;
    pick = 0;
    hit  = 1'b0;
    r    = NOT_FOUND;
    if (w.kind == KIND_WRITE) begin
      sizes_q[l][w.entry_index] = w.entry_size;
      valid_q[l][w.entry_index] = w.entry_valid;
      return 1'b0;
    end
    if (policy_q == POL_NEXT) begin
      for (int i = 0; i < ENTRY_COUNT && !hit; i++) begin
        p = (resume_q[l] + i) % ENTRY_COUNT;
        if (valid_q[l][p] && w.request_size <= sizes_q[l][p]) begin
          hit  = 1'b1;
          pick = p;
        end
      end
      if (hit) resume_q[l] = (pick + 1) % ENTRY_COUNT;
    end else begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        if (!(valid_q[l][i] && w.request_size <= sizes_q[l][i])) continue;
        if (!hit) begin
          hit  = 1'b1;
          pick = i;
          if (policy_q == POL_FIRST) break;
        end else if (policy_q == POL_BEST) begin
          if (sizes_q[l][i] < sizes_q[l][pick]) pick = i;
        end else if (sizes_q[l][i] > sizes_q[l][pick]) begin
          pick = i;
        end
      end
    end
    if (hit) begin
      r.found       = 1'b1;
      r.block_index = pick[INDEX_W-1:0];
      r.block_size  = sizes_q[l][pick];
    end
    return 1'b1;
  endfunction

  function automatic fbfs_in_t write_word(input int l, input int idx,
                                          input logic [FIELD_W-1:0] size, input bit v);
    fbfs_in_t w;
    w.kind         = KIND_WRITE;
    w.list_select  = l[LIST_SEL_W-1:0];
    w.entry_index  = idx[INDEX_W-1:0];
    w.entry_size   = size;
    w.entry_valid  = v;
    w.request_size = $urandom;
    return w;
  endfunction

  function automatic fbfs_in_t search_word(input int l, input logic [FIELD_W-1:0] req);
    fbfs_in_t w;
    w.kind         = KIND_SEARCH;
    w.list_select  = l[LIST_SEL_W-1:0];
    w.entry_index  = INDEX_W'($urandom_range(ENTRY_COUNT - 1));
    w.entry_size   = $urandom;
    w.entry_valid  = 1'($urandom_range(1));
    w.request_size = req;
    return w;
  endfunction

  function automatic fbfs_out_t found_at(input int idx, input logic [FIELD_W-1:0] size);
    fbfs_out_t r;
    r.found       = 1'b1;
    r.block_index = idx[INDEX_W-1:0];
    r.block_size  = size;
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] random_size();
    case ($urandom_range(4))
      0:       return $urandom_range(15);
      1:       return $urandom_range(1000);
      2:       return $urandom;
      3:       return $urandom_range(1) ? '1 : '0;
      default: return 32'hFFFF_FFF0 + $urandom_range(15);
    endcase
  endfunction

  // Requests are often taken from sizes already in the table, so that exact fits,
  // near misses and ties are common.
  function automatic fbfs_in_t random_word(input int valid_pct);
    fbfs_in_t w;
    int       slot;
    w.kind        = ($urandom_range(99) < 45) ? KIND_WRITE : KIND_SEARCH;
    w.list_select = LIST_SEL_W'($urandom_range(LIST_COUNT - 1));
    w.entry_index = INDEX_W'($urandom_range(ENTRY_COUNT - 1));
    w.entry_size  = random_size();
    w.entry_valid = $urandom_range(99) < valid_pct;
    slot          = $urandom_range(ENTRY_COUNT - 1);
    case ($urandom_range(9))
      0, 1, 2, 3: w.request_size = sizes_q[w.list_select][slot];
      4:          w.request_size = sizes_q[w.list_select][slot] + 1;
      5, 6:       w.request_size = $urandom_range(15);
      7:          w.request_size = $urandom;
      8:          w.request_size = '0;
      default:    w.request_size = '1;
    endcase
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic push_word(input fbfs_in_t w, input bit typed, input fbfs_out_t typed_result);
    fbfs_out_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    if (track_word(w, r)) expected_results.push_back(typed ? typed_result : r);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_FIT_POLICY) policy_q = fit_policy_t'(data[1:0]);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_FIT_POLICY;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {{(CFG_DATA_W-2){1'b0}}, policy_q}) begin
      $error("fit_policy readback mismatch: expected %0d, got %0d", policy_q, cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    fbfs_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: found %0d, block_index %0d, block_size %0h",
               out_ch.data.found, out_ch.data.block_index, out_ch.data.block_size);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.data.found !== want.found) begin
          $error("found mismatch: expected %0d, got %0d", want.found, out_ch.data.found);
          fail_count++;
        end
        if (out_ch.data.block_index !== want.block_index) begin
          $error("block_index mismatch: expected %0d, got %0d",
                 want.block_index, out_ch.data.block_index);
          fail_count++;
        end
        if (out_ch.data.block_size !== want.block_size) begin
          $error("block_size mismatch: expected %0h, got %0h",
                 want.block_size, out_ch.data.block_size);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int valid_pct;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;

    script[0]  = '{POL_FIRST, search_word(0, 32'd0), 1'b1, NOT_FOUND};
    script[1]  = '{POL_FIRST, search_word(1, 32'd0), 1'b1, NOT_FOUND};
    script[2]  = '{POL_FIRST, write_word(0, 0, 32'hFFFF_FFFF, 1'b1), 1'b0, NOT_FOUND};
    script[3]  = '{POL_FIRST, write_word(0, 63, 32'd0, 1'b1), 1'b0, NOT_FOUND};
    script[4]  = '{POL_FIRST, write_word(1, 63, 32'hFFFF_FFFF, 1'b1), 1'b0, NOT_FOUND};
    script[5]  = '{POL_FIRST, search_word(0, 32'hFFFF_FFFF), 1'b1,
                   found_at(0, 32'hFFFF_FFFF)};
    script[6]  = '{POL_FIRST, search_word(0, 32'd0), 1'b1, found_at(0, 32'hFFFF_FFFF)};
    script[7]  = '{POL_FIRST, search_word(1, 32'hFFFF_FFFF), 1'b1,
                   found_at(63, 32'hFFFF_FFFF)};
    script[8]  = '{POL_FIRST, write_word(0, 0, 32'd5, 1'b0), 1'b0, NOT_FOUND};
    script[9]  = '{POL_FIRST, search_word(0, 32'd1), 1'b1, NOT_FOUND};
    script[10] = '{POL_FIRST, search_word(0, 32'd0), 1'b1, found_at(63, 32'd0)};
    script[11] = '{POL_FIRST, write_word(0, 10, 32'd100, 1'b1), 1'b0, NOT_FOUND};
    script[12] = '{POL_FIRST, write_word(0, 20, 32'd50, 1'b1), 1'b0, NOT_FOUND};
    script[13] = '{POL_FIRST, write_word(0, 30, 32'd100, 1'b1), 1'b0, NOT_FOUND};
    script[14] = '{POL_FIRST, write_word(0, 40, 32'd50, 1'b1), 1'b0, NOT_FOUND};
    script[15] = '{POL_FIRST, search_word(0, 32'd50), 1'b0, NOT_FOUND};
    script[16] = '{POL_BEST, search_word(0, 32'd50), 1'b0, NOT_FOUND};
    script[17] = '{POL_WORST, search_word(0, 32'd50), 1'b0, NOT_FOUND};
    script[18] = '{POL_WORST, search_word(0, 32'd101), 1'b1, NOT_FOUND};
    script[19] = '{POL_NEXT, search_word(0, 32'd50), 1'b0, NOT_FOUND};
    script[20] = '{POL_NEXT, search_word(0, 32'd50), 1'b0, NOT_FOUND};
    script[21] = '{POL_NEXT, search_word(0, 32'd200), 1'b1, NOT_FOUND};
    script[22] = '{POL_NEXT, search_word(1, 32'd1), 1'b1, found_at(63, 32'hFFFF_FFFF)};
    script[23] = '{POL_NEXT, search_word(1, 32'd0), 1'b1, found_at(63, 32'hFFFF_FFFF)};
    script[24] = '{POL_NEXT, search_word(0, 32'd50), 1'b0, NOT_FOUND};

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A write to an address with no register behind it must leave the policy alone.
    cfg_write(ADDR_NO_REG, {{(CFG_DATA_W-2){1'b0}}, POL_WORST});
    for (int row = 0; row < SCRIPT_ROWS; row++) begin
      if (script[row].pol != policy_q) begin
        settle();
        cfg_write(ADDR_FIT_POLICY, {{(CFG_DATA_W-2){1'b0}}, script[row].pol});
      end
      push_word(script[row].word, script[row].typed, script[row].result);
    end

    for (int blk = 0; blk < BLOCKS; blk++) begin
      if (blk == 4) begin
        src_idle_pct = 77;
        snk_idle_pct = 19;
      end else if (blk == 8) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      settle();
      cfg_write(ADDR_FIT_POLICY, {{(CFG_DATA_W-2){1'b0}}, fit_policy_t'(blk % 4)});
      valid_pct = $urandom_range(30, 90);
      if (blk == 8) hold_req = 1'b1;
      for (int n = 0; n < BLOCK_WORDS; n++) begin
        if (blk == 9 && n == BLOCK_WORDS / 2) settle();
        push_word(random_word(valid_pct), 1'b0, NOT_FOUND);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/fbfs_pkg.sv
src/fbfs_chan_if.sv
src/free_block_fit_search.sv
sim/free_block_fit_search_test.sv
